FILE: rtl/palw_pkg.sv
`timescale 1ns / 1ps
package palw_pkg;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam int unsigned PAGES_W     = 7;
  localparam int unsigned PAGES_RESET = 64;

endpackage

FILE: rtl/paged_array_lru_writeback.sv
`timescale 1ns / 1ps
// A read or write that hits a frame goes straight to the frame; a miss first writes a dirty
// victim back to the store, then loads the page; out of range and unused actions go straight
// to the output; flush writes back each dirty frame in turn.
// The back end takes one item at a time, a new one only when idle and the output is free.
// Reset: frames invalid, LRU rank equals frame number, pages_in_use 64; a clearing
// pass zeroes all PAGE_ELEMS*MAX_PAGES words of the backing store before work starts.
module paged_array_lru_writeback #(
  parameter int unsigned ELEM_BITS  = 32,
  parameter int unsigned PAGE_ELEMS = 64,
  parameter int unsigned MAX_PAGES  = 64,
  parameter int unsigned FRAMES     = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [11:0] in_element_index,
  input  logic [31:0] in_write_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_value,
  output logic        out_was_hit,
  output logic        out_wrote_back,
  output logic [5:0]  out_evicted_page,
  output logic [1:0]  out_used_frame,
  output logic        out_out_of_range
);
  import palw_pkg::*;

  logic        q_valid, q_pop, q_oor;
  logic [1:0]  q_action;
  logic [11:0] q_index;
  logic [31:0] q_value;

  palw_front #(.PAGE_ELEMS(PAGE_ELEMS), .MAX_PAGES(MAX_PAGES), .DEPTH(2)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_element_index(in_element_index), .in_write_value(in_write_value),
    .q_valid(q_valid), .q_pop(q_pop), .q_action(q_action), .q_index(q_index),
    .q_value(q_value), .q_oor(q_oor)
  );

  palw_back #(.ELEM_BITS(ELEM_BITS), .PAGE_ELEMS(PAGE_ELEMS), .MAX_PAGES(MAX_PAGES),
              .FRAMES(FRAMES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_action(q_action),
    .q_index(q_index), .q_value(q_value), .q_oor(q_oor),
    .out_valid(out_valid), .out_stall(out_stall), .out_read_value(out_read_value),
    .out_was_hit(out_was_hit), .out_wrote_back(out_wrote_back),
    .out_evicted_page(out_evicted_page), .out_used_frame(out_used_frame),
    .out_out_of_range(out_out_of_range)
  );
endmodule

FILE: rtl/palw_ram.sv
`timescale 1ns / 1ps
module palw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/palw_front.sv
`timescale 1ns / 1ps
module palw_front #(
  parameter int unsigned PAGE_ELEMS = 64,
  parameter int unsigned MAX_PAGES  = 64,
  parameter int unsigned DEPTH      = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [palw_pkg::PAGES_W-1:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [11:0] in_element_index,
  input  logic [31:0] in_write_value,
  output logic        q_valid,
  input  logic        q_pop,
  output logic [1:0]  q_action,
  output logic [11:0] q_index,
  output logic [31:0] q_value,
  output logic        q_oor
);
  import palw_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned LIM_W = $clog2(PAGE_ELEMS * MAX_PAGES + 1);

  logic [PAGES_W-1:0] pages_r;
  logic [PAGES_W-1:0] pages_sat;
  logic [LIM_W-1:0]   limit;
  logic               oor;
  logic [1:0]  act_q [DEPTH];
  logic [11:0] idx_q [DEPTH];
  logic [31:0] val_q [DEPTH];
  logic        oor_q [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pages_r <= PAGES_W'(PAGES_RESET);
    end else if (cfg_we) begin
      pages_r <= cfg_wdata;
    end
  end

  assign pages_sat = (32'(pages_r) > MAX_PAGES) ? PAGES_W'(MAX_PAGES) : pages_r;
  assign limit     = LIM_W'(pages_sat) * LIM_W'(PAGE_ELEMS);
  assign oor       = (32'(in_element_index) >= 32'(limit));

  assign in_stall = (cnt_r == CNT_W'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_action = act_q[rp_r];
  assign q_index  = idx_q[rp_r];
  assign q_value  = val_q[rp_r];
  assign q_oor    = oor_q[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      act_q[wp_r] <= in_action;
      idx_q[wp_r] <= in_element_index;
      val_q[wp_r] <= in_write_value;
      oor_q[wp_r] <= oor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (32'(wp_r) == DEPTH - 1) ? '0 : wp_r + 1'b1;
      end
      if (q_pop) begin
        rp_r <= (32'(rp_r) == DEPTH - 1) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(q_pop);
    end
  end
endmodule

FILE: rtl/palw_back.sv
`timescale 1ns / 1ps
module palw_back #(
  parameter int unsigned ELEM_BITS  = 32,
  parameter int unsigned PAGE_ELEMS = 64,
  parameter int unsigned MAX_PAGES  = 64,
  parameter int unsigned FRAMES     = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_pop,
  input  logic [1:0]  q_action,
  input  logic [11:0] q_index,
  input  logic [31:0] q_value,
  input  logic        q_oor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_value,
  output logic        out_was_hit,
  output logic        out_wrote_back,
  output logic [5:0]  out_evicted_page,
  output logic [1:0]  out_used_frame,
  output logic        out_out_of_range
);
  import palw_pkg::*;

  localparam int unsigned OFF_W  = $clog2(PAGE_ELEMS);
  localparam int unsigned PAGE_W = $clog2(MAX_PAGES);
  localparam int unsigned FR_W   = $clog2(FRAMES);
  localparam int unsigned SD     = PAGE_ELEMS * MAX_PAGES;
  localparam int unsigned SA_W   = PAGE_W + OFF_W;
  localparam int unsigned FD     = PAGE_ELEMS * FRAMES;
  localparam int unsigned FA_W   = FR_W + OFF_W;
  localparam int unsigned CNT_W  = OFF_W + 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_DECIDE= 9'b000000100,
    S_WB    = 9'b000001000,
    S_LD    = 9'b000010000,
    S_ACC   = 9'b000100000,
    S_RD    = 9'b001000000,
    S_FLUSH = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [PAGE_W-1:0] fpage_r [FRAMES];
  logic [FRAMES-1:0] fvalid_r, fdirty_r;
  logic [FR_W-1:0]   rank_r [FRAMES];

  logic [1:0]        act_r;
  logic [PAGE_W-1:0] page_r;
  logic [OFF_W-1:0]  off_r;
  logic [ELEM_BITS-1:0] val_r;
  logic [FR_W-1:0]   f_r;
  logic              hit_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SA_W-1:0]   clr_r;
  logic              rd_valid_r;
  logic [OFF_W-1:0]  rd_off_r;
  logic [PAGE_W-1:0] wb_page_r;
  logic [FR_W-1:0]   fl_r;

  logic              ov_r;
  logic [31:0]       o_rv_r;
  logic              o_hit_r, o_wb_r, o_oor_r;
  logic [5:0]        o_ev_r;
  logic [1:0]        o_uf_r;

  logic              s_we;
  logic [SA_W-1:0]   s_wa, s_ra;
  logic [ELEM_BITS-1:0] s_wd, s_rd;
  logic              f_we;
  logic [FA_W-1:0]   f_wa, f_ra;
  logic [ELEM_BITS-1:0] f_wd, f_rd;

  logic [PAGE_W-1:0] q_page;
  logic [OFF_W-1:0]  q_off;
  logic              hit_c;
  logic [FR_W-1:0]   hit_f, vic_f;
  logic              out_free;

  palw_ram #(.WIDTH(ELEM_BITS), .DEPTH(SD)) u_store (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
  );
  palw_ram #(.WIDTH(ELEM_BITS), .DEPTH(FD)) u_frames (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd)
  );

  assign q_page = PAGE_W'(q_index >> OFF_W);
  assign q_off  = OFF_W'(q_index);

  always_comb begin
    hit_c = 1'b0;
    hit_f = '0;
    vic_f = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (fvalid_r[i] && fpage_r[i] == page_r) begin
        hit_c = 1'b1;
        hit_f = FR_W'(i);
      end
      if (rank_r[i] == '0) begin
        vic_f = FR_W'(i);
      end
    end
  end

  assign out_free = !ov_r || !out_stall;
  assign q_pop    = (state_r == S_IDLE) && q_valid && out_free;

  always_comb begin
    state_nxt = state_r;
    s_we = 1'b0;
    s_wa = clr_r;
    s_wd = '0;
    s_ra = {page_r, OFF_W'(cnt_r)};
    f_we = 1'b0;
    f_wa = {f_r, rd_off_r};
    f_wd = s_rd;
    f_ra = {f_r, OFF_W'(cnt_r)};
    case (state_r)
      S_CLEAR: begin
        s_we = 1'b1;
        if (32'(clr_r) == SD - 1) state_nxt = S_IDLE;
      end
      S_IDLE: if (q_pop) begin
        if (q_action == ACT_FLUSH) state_nxt = S_FLUSH;
        else if (q_action == ACT_NONE || q_oor) state_nxt = S_OUT;
        else state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (hit_c) state_nxt = S_ACC;
        else if (fvalid_r[vic_f] && fdirty_r[vic_f]) state_nxt = S_WB;
        else state_nxt = S_LD;
      end
      S_FLUSH: begin
        f_ra = {fl_r, OFF_W'(cnt_r)};
        if (fvalid_r[fl_r] && fdirty_r[fl_r]) state_nxt = S_WB;
        else if (32'(fl_r) == FRAMES - 1) state_nxt = S_OUT;
      end
      S_WB: begin
        f_ra = {(act_r == ACT_FLUSH) ? fl_r : f_r, OFF_W'(cnt_r)};
        s_we = rd_valid_r;
        s_wa = {wb_page_r, rd_off_r};
        s_wd = f_rd;
        if (rd_valid_r && 32'(rd_off_r) == PAGE_ELEMS - 1) begin
          if (act_r == ACT_FLUSH)
            state_nxt = (32'(fl_r) == FRAMES - 1) ? S_OUT : S_FLUSH;
          else
            state_nxt = S_LD;
        end
      end
      S_LD: begin
        f_we = rd_valid_r;
        if (rd_valid_r && 32'(rd_off_r) == PAGE_ELEMS - 1) state_nxt = S_ACC;
      end
      S_ACC: begin
        f_we = (act_r == ACT_WRITE);
        f_wa = {f_r, off_r};
        f_wd = val_r;
        f_ra = {f_r, off_r};
        state_nxt = (act_r == ACT_WRITE) ? S_OUT : S_RD;
      end
      S_RD: state_nxt = S_OUT;
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      fvalid_r <= '0;
      fdirty_r <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_r[i]  <= FR_W'(i);
        fpage_r[i] <= '0;
      end
      ov_r <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (ov_r && !out_stall) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: if (q_pop) begin
          act_r   <= q_action;
          page_r  <= q_page;
          off_r   <= q_off;
          val_r   <= ELEM_BITS'(q_value);
          o_rv_r  <= '0;
          o_hit_r <= 1'b0;
          o_wb_r  <= 1'b0;
          o_ev_r  <= '0;
          o_uf_r  <= '0;
          o_oor_r <= (q_action != ACT_FLUSH) && (q_action != ACT_NONE) && q_oor;
          fl_r    <= '0;
          cnt_r   <= '0;
        end
        S_DECIDE: begin
          hit_r <= hit_c;
          f_r   <= hit_c ? hit_f : vic_f;
          cnt_r <= '0;
          if (!hit_c && fvalid_r[vic_f] && fdirty_r[vic_f]) begin
            wb_page_r <= fpage_r[vic_f];
            o_wb_r    <= 1'b1;
            o_ev_r    <= 6'(fpage_r[vic_f]);
          end
        end
        S_FLUSH: begin
          if (fvalid_r[fl_r] && fdirty_r[fl_r]) begin
            wb_page_r <= fpage_r[fl_r];
            o_wb_r    <= 1'b1;
            cnt_r     <= CNT_W'(1);
            rd_valid_r <= 1'b1;
            rd_off_r  <= '0;
          end else begin
            cnt_r      <= '0;
            rd_valid_r <= 1'b0;
            if (32'(fl_r) != FRAMES - 1) fl_r <= fl_r + 1'b1;
          end
        end
        S_WB, S_LD: begin
          if (32'(cnt_r) < PAGE_ELEMS) begin
            cnt_r      <= cnt_r + 1'b1;
            rd_valid_r <= 1'b1;
            rd_off_r   <= OFF_W'(cnt_r);
          end else begin
            rd_valid_r <= 1'b0;
          end
          if (rd_valid_r && 32'(rd_off_r) == PAGE_ELEMS - 1) begin
            cnt_r <= '0;
            if (state_r == S_WB) begin
              if (act_r == ACT_FLUSH) begin
                fdirty_r[fl_r] <= 1'b0;
                if (32'(fl_r) != FRAMES - 1) fl_r <= fl_r + 1'b1;
              end else begin
                fdirty_r[f_r] <= 1'b0;
              end
            end else begin
              fpage_r[f_r]  <= page_r;
              fvalid_r[f_r] <= 1'b1;
              fdirty_r[f_r] <= 1'b0;
            end
          end
        end
        S_ACC: begin
          if (act_r == ACT_WRITE) fdirty_r[f_r] <= 1'b1;
          for (int i = 0; i < FRAMES; i++) begin
            if (rank_r[i] > rank_r[f_r]) rank_r[i] <= rank_r[i] - 1'b1;
          end
          rank_r[f_r] <= FR_W'(FRAMES - 1);
          o_hit_r <= hit_r;
          o_uf_r  <= 2'(f_r);
        end
        S_RD: o_rv_r <= 32'(f_rd);
        S_OUT: ov_r <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid        = ov_r;
  assign out_read_value   = o_rv_r;
  assign out_was_hit      = o_hit_r;
  assign out_wrote_back   = o_wb_r;
  assign out_evicted_page = o_ev_r;
  assign out_used_frame   = o_uf_r;
  assign out_out_of_range = o_oor_r;
endmodule
